[rtl/bbip_pkg.sv]
// Shared widths, constants and types for the bit-plane inner product block.
// No dependencies; imported by every module of the block.
`default_nettype none

package bbip_pkg;

   // field widths
   localparam int WORD_W      = 64;
   localparam int NUM_PLANES  = 8;
   localparam int SCALE_W     = 32;
   localparam int COUNT_W     = 7;     // popcount of one 64-bit word, 0..64
   localparam int ADD_W       = 15;    // weighted plane sum of one word
   localparam int INNER_W     = 20;
   localparam int ONES_W      = 13;
   localparam int EST_W       = 64;
   localparam int PLANE_CNT_W = 4;

   // request payload layout: data word, eight plane words, two scales
   localparam int PLANE_LSB   = WORD_W;
   localparam int DELTA_LSB   = WORD_W * (NUM_PLANES + 1);
   localparam int VL_LSB      = DELTA_LSB + SCALE_W;
   localparam int REQ_DATA_W  = VL_LSB + SCALE_W;

   // response payload layout: estimate, inner sum, ones count, zero pad
   localparam int RSP_INNER_LSB = EST_W;
   localparam int RSP_ONES_LSB  = RSP_INNER_LSB + INNER_W;
   localparam int RSP_USED_W    = RSP_ONES_LSB + ONES_W;
   localparam int RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic [INNER_W-1:0]     INNER_MAX       = '1;
   localparam logic [ONES_W-1:0]      ONES_MAX        = '1;
   localparam logic [PLANE_CNT_W-1:0] PLANE_CNT_RESET = 4'd4;

   typedef logic [NUM_PLANES-1:0][COUNT_W-1:0] count_array_type;

   // sums and scales captured on the last word of a vector
   typedef struct packed {
      logic [INNER_W-1:0] inner;
      logic [ONES_W-1:0]  ones;
      logic [SCALE_W-1:0] delta;
      logic [SCALE_W-1:0] vl;
   } snap_type;

endpackage : bbip_pkg

`default_nettype wire

[rtl/bbip_popcount.sv]
// Combinational population count of one 64-bit word.
// Depends on bbip_pkg for widths.
`default_nettype none

module bbip_popcount (
   input  logic [bbip_pkg::WORD_W-1:0]  word,
   output logic [bbip_pkg::COUNT_W-1:0] count
);
   import bbip_pkg::*;

   logic [WORD_W-1:0] pair_sum;
   logic [WORD_W-1:0] nib_sum;
   logic [WORD_W-1:0] byte_sum;

   // bit pairs, nibbles, then bytes, each field summed in place
   assign pair_sum = word - ((word >> 1) & 64'h5555_5555_5555_5555);
   assign nib_sum  = (pair_sum & 64'h3333_3333_3333_3333)
                   + ((pair_sum >> 2) & 64'h3333_3333_3333_3333);
   assign byte_sum = (nib_sum + (nib_sum >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;

   // add the eight byte counts
   always_comb begin
      logic [COUNT_W-1:0] acc;
      acc = '0;
      for (int b = 0; b < WORD_W / 8; b++) begin
         acc = acc + COUNT_W'(byte_sum[8*b +: 4]);
      end
      count = acc;
   end

endmodule : bbip_popcount

`default_nettype wire

[rtl/bbip_accum.sv]
// Running ones and weighted inner sums with saturation.
// Depends on bbip_pkg; fed with per-word popcounts from the top level.
`default_nettype none

module bbip_accum (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,        // word consumed
   input  logic                             clear,       // word was the last one
   input  logic [bbip_pkg::COUNT_W-1:0]     ones_add,
   input  bbip_pkg::count_array_type        plane_counts,
   output logic [bbip_pkg::INNER_W-1:0]     inner_total,
   output logic [bbip_pkg::ONES_W-1:0]      ones_total
);
   import bbip_pkg::*;

   logic [INNER_W-1:0] inner_acc_ff, inner_acc_in;
   logic [ONES_W-1:0]  ones_acc_ff, ones_acc_in;
   logic [ADD_W-1:0]   inner_add;
   logic [INNER_W:0]   inner_raw;
   logic [ONES_W:0]    ones_raw;

   // weight plane p by 2^p
   always_comb begin
      logic [ADD_W-1:0] acc;
      acc = '0;
      for (int p = 0; p < NUM_PLANES; p++) begin
         acc = acc + (ADD_W'(plane_counts[p]) << p);
      end
      inner_add = acc;
   end

   // saturating sums including the current word
   assign inner_raw   = (INNER_W+1)'(inner_acc_ff) + (INNER_W+1)'(inner_add);
   assign ones_raw    = (ONES_W+1)'(ones_acc_ff) + (ONES_W+1)'(ones_add);
   assign inner_total = inner_raw[INNER_W] ? INNER_MAX : inner_raw[INNER_W-1:0];
   assign ones_total  = ones_raw[ONES_W] ? ONES_MAX : ones_raw[ONES_W-1:0];

   assign inner_acc_in = clear ? '0 : inner_total;
   assign ones_acc_in  = clear ? '0 : ones_total;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_acc_ff <= '0;
         ones_acc_ff  <= '0;
      end else if (step) begin
         inner_acc_ff <= inner_acc_in;
         ones_acc_ff  <= ones_acc_in;
      end
   end

endmodule : bbip_accum

`default_nettype wire

[rtl/bbip_estimate.sv]
// Scaling products and final sum, ending in the response output register.
// Depends on bbip_pkg; takes one snapshot per vector from the top level.
`default_nettype none

module bbip_estimate (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             snap_valid,
   input  bbip_pkg::snap_type               snap,
   output logic                             snap_ready,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bbip_pkg::EST_W-1:0]       estimate,
   output logic [bbip_pkg::INNER_W-1:0]     inner_sum,
   output logic [bbip_pkg::ONES_W-1:0]      ones_count
);
   import bbip_pkg::*;

   localparam int PD_W = SCALE_W + INNER_W + 1;
   localparam int PV_W = SCALE_W + ONES_W + 1;

   logic                     out_free;
   logic                     prod_valid_ff;
   logic signed [PD_W-1:0]   prod_d_ff, prod_d_in;
   logic signed [PV_W-1:0]   prod_v_ff, prod_v_in;
   logic [INNER_W-1:0]       prod_inner_ff;
   logic [ONES_W-1:0]        prod_ones_ff;
   logic [EST_W-1:0]         estimate_in;
   logic                     rsp_valid_ff;
   logic [EST_W-1:0]         estimate_ff;
   logic [INNER_W-1:0]       inner_ff;
   logic [ONES_W-1:0]        ones_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign snap_ready = !prod_valid_ff || out_free;

   // one multiplier per scale, registered before the add
   assign prod_d_in = $signed(snap.delta) * $signed({1'b0, snap.inner});
   assign prod_v_in = $signed(snap.vl) * $signed({1'b0, snap.ones});

   assign estimate_in = EST_W'(prod_d_ff) + EST_W'(prod_v_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (snap_ready) prod_valid_ff <= snap_valid;
         if (out_free)   rsp_valid_ff  <= prod_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (snap_ready) begin
         prod_d_ff     <= prod_d_in;
         prod_v_ff     <= prod_v_in;
         prod_inner_ff <= snap.inner;
         prod_ones_ff  <= snap.ones;
      end
      if (out_free) begin
         estimate_ff <= estimate_in;
         inner_ff    <= prod_inner_ff;
         ones_ff     <= prod_ones_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign estimate   = estimate_ff;
   assign inner_sum  = inner_ff;
   assign ones_count = ones_ff;

endmodule : bbip_estimate

`default_nettype wire

[rtl/bitplane_binary_inner_product.sv]
// Top level of the bit-plane binary inner product block.
// Depends on bbip_pkg, bbip_popcount, bbip_accum and bbip_estimate.
//
// Usage:
//   req_*  : one transfer per 64-bit code word with the matching words of the
//            query bit planes and the two Q16.16 scales; req_tlast marks the
//            final word of a vector. Scales are only used on that word.
//   rsp_*  : one transfer per vector: estimate = delta*inner + vl*ones (16
//            fraction bits), plus the raw inner sum and ones count.
//   csr_*  : plane_count write; plane p counts only when p < plane_count.
//            Write only while no vector is in flight.
// Throughput: one word per cycle while rsp_tready keeps results moving. There are
// five register stages: input, popcount, accumulator/snapshot, products, output.
// The result of a vector passes through them in that order after its last word.
// Stall: words that are not last keep flowing into the sums while a result
// waits; a last word waits in the popcount stage only once the snapshot,
// product and output stages are all full.
// Reset: sums cleared, pipeline emptied, plane_count returns to 4.
`default_nettype none

module bitplane_binary_inner_product #(
   parameter int MAX_PLANES = 8        // 1..8 plane lanes built
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: data_word, plane_word_0..7, scale_delta, scale_vl (low bit up)
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bbip_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                  req_tlast,   // last_word
   // response: estimate, inner_sum, ones_count, zero pad (low bit up)
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bbip_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // plane_count register
   input  logic                                  csr_wr_en,
   input  logic [bbip_pkg::PLANE_CNT_W-1:0]      csr_wr_data
);
   import bbip_pkg::*;

   logic [PLANE_CNT_W-1:0] plane_count_ff;

   // input stage
   logic                   in_valid_ff;
   logic [REQ_DATA_W-1:0]  in_data_ff;
   logic                   in_last_ff;
   logic                   in_ready;

   // popcount stage
   logic                   pc_valid_ff;
   logic [COUNT_W-1:0]     pc_ones_ff, pc_ones_in;
   count_array_type        pc_planes_ff, pc_planes_in;
   logic [SCALE_W-1:0]     pc_delta_ff, pc_vl_ff;
   logic                   pc_last_ff;
   logic                   pc_ready;
   logic                   acc_step;

   // snapshot stage
   logic                   snap_valid_ff;
   snap_type               snap_ff, snap_in;
   logic                   snap_ready;
   logic                   est_ready;
   logic [INNER_W-1:0]     inner_total;
   logic [ONES_W-1:0]      ones_total;

   logic [EST_W-1:0]       estimate;
   logic [INNER_W-1:0]     inner_sum;
   logic [ONES_W-1:0]      ones_count;

   // ready chain: a stage moves when empty or when its successor moves
   assign snap_ready = !snap_valid_ff || est_ready;
   assign acc_step   = pc_valid_ff && (!pc_last_ff || snap_ready);
   assign pc_ready   = !pc_valid_ff || acc_step;
   assign in_ready   = !in_valid_ff || pc_ready;
   assign req_tready = in_ready;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff <= PLANE_CNT_RESET;
      end else if (csr_wr_en) begin
         plane_count_ff <= csr_wr_data;
      end
   end

   // popcount lanes
   bbip_popcount u_pop_data (
      .word  (in_data_ff[WORD_W-1:0]),
      .count (pc_ones_in)
   );

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      if (p < MAX_PLANES) begin : g_lane
         logic [COUNT_W-1:0] lane_count;
         bbip_popcount u_pop_plane (
            .word  (in_data_ff[WORD_W-1:0] & in_data_ff[PLANE_LSB + p*WORD_W +: WORD_W]),
            .count (lane_count)
         );
         assign pc_planes_in[p] = (PLANE_CNT_W'(p) < plane_count_ff) ? lane_count : '0;
      end else begin : g_off
         assign pc_planes_in[p] = '0;
      end
   end

   // accumulators
   bbip_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .step         (acc_step),
      .clear        (pc_last_ff),
      .ones_add     (pc_ones_ff),
      .plane_counts (pc_planes_ff),
      .inner_total  (inner_total),
      .ones_total   (ones_total)
   );

   assign snap_in = '{inner: inner_total, ones: ones_total,
                      delta: pc_delta_ff, vl: pc_vl_ff};

   // valid bits of the input, popcount and snapshot stages
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pc_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         if (in_ready)   in_valid_ff   <= req_tvalid;
         if (pc_ready)   pc_valid_ff   <= in_valid_ff;
         if (snap_ready) snap_valid_ff <= pc_valid_ff && pc_last_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (pc_ready) begin
         pc_ones_ff   <= pc_ones_in;
         pc_planes_ff <= pc_planes_in;
         pc_delta_ff  <= in_data_ff[DELTA_LSB +: SCALE_W];
         pc_vl_ff     <= in_data_ff[VL_LSB +: SCALE_W];
         pc_last_ff   <= in_last_ff;
      end
      if (snap_ready) begin
         snap_ff <= snap_in;
      end
   end

   // products, final sum and output register
   bbip_estimate u_estimate (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid_ff),
      .snap       (snap_ff),
      .snap_ready (est_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .estimate   (estimate),
      .inner_sum  (inner_sum),
      .ones_count (ones_count)
   );

   assign rsp_tdata = {(RSP_DATA_W-RSP_USED_W)'(0), ones_count, inner_sum, estimate};

   // a last word that cannot move on stays put, still marked last
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (pc_valid_ff && pc_last_ff && !snap_ready) |=> (pc_valid_ff && pc_last_ff))
      else $error("last word dropped while snapshot stage was full");

   // a consumed last word always lands in the snapshot stage
   a_last_pushed: assert property (@(posedge clock) disable iff (reset)
      (acc_step && pc_last_ff) |=> snap_valid_ff)
      else $error("snapshot missing after last word");

   // a snapshot blocked by the product stage holds its contents
   a_snap_hold: assert property (@(posedge clock) disable iff (reset)
      (snap_valid_ff && !est_ready) |=> (snap_valid_ff && $stable(snap_ff)))
      else $error("snapshot changed while stalled");

endmodule : bitplane_binary_inner_product

`default_nettype wire
